// ===== rtl/sorted_key_balance_lookup_core_assert.svh =====
// Assertion macros for the sorted key and balance lookup core.
// Included by the top level; needs nothing else.
`ifndef SORTED_KEY_BALANCE_LOOKUP_CORE_ASSERT_SVH
`define SORTED_KEY_BALANCE_LOOKUP_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKBL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/skbl_pkg.sv =====
// Shared types and constants of the sorted key and balance lookup core.
// Used by the controller, the datapath and the top level.
`default_nettype none

package skbl_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned BalW   = 24;
  localparam int unsigned LimitW = 23;

  localparam logic [LimitW-1:0] LimitReset = 23'd10000;

  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqLookup = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_A,
    ST_LOAD_A,
    ST_READ_B,
    ST_CMP_B,
    ST_WRITE_A,
    ST_READ_I,
    ST_CMP_I,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_I
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_LOAD,
    WR_B,
    WR_A
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    look;
    logic    sort_init;
    logic    cap_cur;
    logic    cmp_b;
    logic    adv_a;
    logic    adv_i;
    logic    res_set;
    logic    emit;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
  } cmd_t;

  typedef struct packed {
    logic sort_more;
    logic b_last;
    logic srch_more;
    logic key_lt;
    logic key_eq;
    logic key_gt;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/skbl_dpath.sv =====
// Datapath of the lookup core: key and balance memories, sort and search
// counters, result and output registers. Uses skbl_pkg.
`default_nettype none

module skbl_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire skbl_pkg::cmd_t              cmd_i,
  output skbl_pkg::sts_t                   sts_o,
  input  wire logic [skbl_pkg::KeyW-1:0]   in_key_i,
  input  wire logic [skbl_pkg::BalW-1:0]   in_bal_i,
  input  wire logic                        in_last_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [skbl_pkg::LimitW-1:0] cfg_data_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_hit_o,
  output logic [skbl_pkg::BalW-1:0]        out_bal_o,
  output logic                             out_over_o
);
  import skbl_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [KeyW-1:0]   key_mem [ENTRIES];
  logic [BalW-1:0]   bal_mem [ENTRIES];

  logic [CW-1:0]     count_q, count_d;
  logic              closed_q, closed_d;
  logic [CW-1:0]     a_q, a_d, b_q, b_d, i_q, i_d;
  logic [KeyW-1:0]   cur_key_q, cur_key_d;
  logic [BalW-1:0]   cur_bal_q, cur_bal_d;
  logic [KeyW-1:0]   query_q, query_d;
  logic [KeyW-1:0]   rd_key_q;
  logic [BalW-1:0]   rd_bal_q;
  logic              res_hit_q, res_hit_d;
  logic [BalW-1:0]   res_bal_q, res_bal_d;
  logic [LimitW-1:0] limit_q;
  logic              out_valid_q;
  logic              out_hit_q;
  logic [BalW-1:0]   out_bal_q;
  logic              out_over_q;

  logic [CW-1:0]     eff_count;
  logic              full;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [KeyW-1:0]   wr_key;
  logic [BalW-1:0]   wr_bal;

  // A load after a closed set starts a new set from slot zero.
  assign eff_count = closed_q ? '0 : count_q;
  assign full      = (eff_count == CW'(ENTRIES));

  always_comb begin
    case (cmd_i.rd_sel)
      RD_A:    rd_addr = a_q[AW-1:0];
      RD_B:    rd_addr = b_q[AW-1:0];
      default: rd_addr = i_q[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = a_q[AW-1:0];
    wr_key  = cur_key_q;
    wr_bal  = cur_bal_q;
    case (cmd_i.wr_sel)
      WR_LOAD: begin
        wr_en   = !full;
        wr_addr = eff_count[AW-1:0];
        wr_key  = in_key_i;
        wr_bal  = in_bal_i;
      end
      WR_B: begin
        wr_en   = 1'b1;
        wr_addr = b_q[AW-1:0];
      end
      WR_A: begin
        wr_en   = 1'b1;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      bal_mem[wr_addr] <= wr_bal;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[rd_addr];
    rd_bal_q <= bal_mem[rd_addr];
  end

  always_comb begin
    count_d   = count_q;
    closed_d  = closed_q;
    a_d       = a_q;
    b_d       = b_q;
    i_d       = i_q;
    cur_key_d = cur_key_q;
    cur_bal_d = cur_bal_q;
    query_d   = query_q;
    res_hit_d = res_hit_q;
    res_bal_d = res_bal_q;
    if (cmd_i.load) begin
      count_d  = full ? eff_count : eff_count + CW'(1);
      closed_d = in_last_i;
    end
    if (cmd_i.look) begin
      query_d   = in_key_i;
      i_d       = '0;
      res_hit_d = 1'b0;
      res_bal_d = '0;
    end
    if (cmd_i.sort_init) begin
      a_d = '0;
    end
    if (cmd_i.cap_cur) begin
      cur_key_d = rd_key_q;
      cur_bal_d = rd_bal_q;
      b_d       = a_q + CW'(1);
    end
    // The slot-a pair rides in cur until the inner pass ends; a smaller key
    // trades places with it.
    if (cmd_i.cmp_b) begin
      if (rd_key_q < cur_key_q) begin
        cur_key_d = rd_key_q;
        cur_bal_d = rd_bal_q;
      end
      b_d = b_q + CW'(1);
    end
    if (cmd_i.adv_a) begin
      a_d = a_q + CW'(1);
    end
    if (cmd_i.adv_i) begin
      i_d = i_q + CW'(1);
    end
    if (cmd_i.res_set) begin
      res_hit_d = 1'b1;
      res_bal_d = rd_bal_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      closed_q <= 1'b0;
      limit_q  <= LimitReset;
    end else begin
      count_q  <= count_d;
      closed_q <= closed_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    i_q       <= i_d;
    cur_key_q <= cur_key_d;
    cur_bal_q <= cur_bal_d;
    query_q   <= query_d;
    res_hit_q <= res_hit_d;
    res_bal_q <= res_bal_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_hit_q  <= res_hit_q;
      out_bal_q  <= res_bal_q;
      out_over_q <= res_hit_q && ($signed(res_bal_q) > $signed({1'b0, limit_q}));
    end
  end

  assign sts_o.sort_more = (a_q + CW'(1)) < count_q;
  assign sts_o.b_last    = (b_q + CW'(1)) == count_q;
  assign sts_o.srch_more = i_q < count_q;
  assign sts_o.key_lt    = rd_key_q < cur_key_q;
  assign sts_o.key_eq    = rd_key_q == query_q;
  assign sts_o.key_gt    = rd_key_q > query_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_bal_o   = out_bal_q;
  assign out_over_o  = out_over_q;

endmodule

`default_nettype wire

// ===== rtl/skbl_ctrl.sv =====
// Controller of the lookup core: sequences loads, the exchange sort and the
// early-exit search. Uses skbl_pkg; drives skbl_dpath by commands.
`default_nettype none

module skbl_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_type_i,
  input  wire logic           in_last_i,
  output logic                in_ready_o,
  input  wire skbl_pkg::sts_t sts_i,
  output skbl_pkg::cmd_t      cmd_o
);
  import skbl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_sel  = RD_I;
    cmd_o.wr_sel  = WR_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_type_i == ReqLookup) begin
            cmd_o.look = 1'b1;
            state_d    = ST_READ_I;
          end else begin
            cmd_o.load   = 1'b1;
            cmd_o.wr_sel = WR_LOAD;
            if (in_last_i) begin
              cmd_o.sort_init = 1'b1;
              state_d         = ST_SORT_A;
            end
          end
        end
      end
      ST_SORT_A: begin
        if (sts_i.sort_more) begin
          cmd_o.rd_sel = RD_A;
          state_d      = ST_LOAD_A;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD_A: begin
        cmd_o.cap_cur = 1'b1;
        state_d       = ST_READ_B;
      end
      ST_READ_B: begin
        cmd_o.rd_sel = RD_B;
        state_d      = ST_CMP_B;
      end
      ST_CMP_B: begin
        cmd_o.cmp_b = 1'b1;
        if (sts_i.key_lt) begin
          cmd_o.wr_sel = WR_B;
        end
        state_d = sts_i.b_last ? ST_WRITE_A : ST_READ_B;
      end
      ST_WRITE_A: begin
        cmd_o.wr_sel = WR_A;
        cmd_o.adv_a  = 1'b1;
        state_d      = ST_SORT_A;
      end
      ST_READ_I: begin
        if (sts_i.srch_more) begin
          cmd_o.rd_sel = RD_I;
          state_d      = ST_CMP_I;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_CMP_I: begin
        if (sts_i.key_eq) begin
          cmd_o.res_set = 1'b1;
          state_d       = ST_EMIT;
        end else if (sts_i.key_gt) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.adv_i = 1'b1;
          state_d     = ST_READ_I;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_balance_lookup_core.sv =====
// Top level of the sorted key and balance lookup core.
// Instantiates skbl_ctrl and skbl_dpath; uses skbl_pkg and the assert header.
`default_nettype none
`include "sorted_key_balance_lookup_core_assert.svh"

// Loads key and balance pairs one request at a time into a store of ENTRIES
// slots; the load with tlast set closes the set and starts an exchange sort
// by ascending key. A lookup request walks the stored keys from slot zero and
// stops at the first equal or greater key, returning hit, the balance and an
// over-limit flag. Every memory read has a registered output and is compared
// in the following cycle. The sort runs through the single read and single
// write port of the store and holds off the next request after the closing
// load; no request is taken while it runs. A finished result sits in the
// output register while the next request is taken; a lookup whose result
// finds that register still occupied waits there and stalls the input.
// The credit limit may be written at any time the core is idle.
module sorted_key_balance_lookup_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // [15:0] entry_key, [39:16] entry_balance
  input  wire logic [39:0] s_axis_tdata_i,
  // [0] req_type
  input  wire logic [0:0]  s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [0] hit, [24:1] found_balance, [25] over_limit, [31:26] zero
  output logic [31:0]      m_axis_tdata_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [22:0] cfg_data_i
);
  import skbl_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic            in_ready;
  logic            out_hit;
  logic [BalW-1:0] out_bal;
  logic            out_over;

  skbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_type_i  (s_axis_tuser_i[0]),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  skbl_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_key_i    (s_axis_tdata_i[15:0]),
    .in_bal_i    (s_axis_tdata_i[39:16]),
    .in_last_i   (s_axis_tlast_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_hit_o   (out_hit),
    .out_bal_o   (out_bal),
    .out_over_o  (out_over)
  );

  assign s_axis_tready_o = in_ready;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tdata_o  = {6'd0, out_over, out_bal, out_hit};

  `SKBL_ASSERT_IMPL(a_emit_slot_free, clk_i, rst_ni, cmd.emit, sts.out_free, "result overwritten")
  `SKBL_ASSERT_IMPL(a_no_req_in_sort, clk_i, rst_ni, cmd.wr_sel == WR_B, !s_axis_tready_o, "request taken during sort")
  `SKBL_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, cmd.emit, m_axis_tvalid_o, "emitted result not shown")

endmodule

`default_nettype wire

// ===== verif/tb_sorted_key_balance_lookup_core.sv =====
// Self-checking testbench of sorted_key_balance_lookup_core: loads, sorts and looks up
// key and balance sets under random stalls on both stream sides.
// Depends on skbl_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_sorted_key_balance_lookup_core;
  import skbl_pkg::*;

  localparam int unsigned ENTRIES   = 16;
  // Longest quiet spell of the core: a full sort of the store plus a lookup.
  localparam int unsigned SETTLE    = 2 * ENTRIES * ENTRIES + 4 * ENTRIES + 64;
  localparam int unsigned STALL_LEN = 400;
  localparam int unsigned MAX_CYC   = 2_000_000;
  localparam int unsigned N_ITEMS   = 1550;

  typedef struct packed {
    logic        over_limit;
    logic [23:0] found_balance;
    logic        hit;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [39:0] s_axis_tdata_i = '0;   // [15:0] entry_key, [39:16] entry_balance
  logic [0:0]  s_axis_tuser_i = '0;   // [0] req_type
  logic        s_axis_tlast_i = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] m_axis_tdata_o;        // [0] hit, [24:1] found_balance, [25] over_limit
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [22:0] cfg_data_i = '0;

  sorted_key_balance_lookup_core #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5;
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
  end

  // Shadow copy of the store and the credit limit.
  logic [15:0]  key_mem [ENTRIES];
  logic [23:0]  bal_mem [ENTRIES];
  int unsigned  n_stored = 0;
  bit           set_done = 1'b0;
  logic [22:0]  limit_q = LimitReset;

  answer_t      pending_answers[$];
  int unsigned  n_items = 0;
  int unsigned  n_lookups = 0;
  int unsigned  n_hits = 0;
  int unsigned  n_limits = 0;
  int unsigned  n_errors = 0;
  int unsigned  cycles = 0;
  bit           steady = 1'b0;
  bit           stall_req = 1'b0;
  bit           stall_done = 1'b0;
  int unsigned  stall_cnt = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_mem[i] = '0;
      bal_mem[i] = '0;
    end
  end

  function automatic void book_load(input logic [15:0] key, input logic [23:0] bal,
                                    input logic last);
    logic [15:0] tk;
    logic [23:0] tb;
    if (set_done) begin
      n_stored = 0;
      set_done = 1'b0;
    end
    if (n_stored < ENTRIES) begin
      key_mem[n_stored] = key;
      bal_mem[n_stored] = bal;
      n_stored++;
    end
    if (last) begin
      // Exchange sort, run to the end; balances travel with their keys.
      for (int a = 0; a + 1 < n_stored; a++) begin
        for (int b = a; b < n_stored; b++) begin
          if (key_mem[b] < key_mem[a]) begin
            tk = key_mem[b];
            tb = bal_mem[b];
            key_mem[b] = key_mem[a];
            bal_mem[b] = bal_mem[a];
            key_mem[a] = tk;
            bal_mem[a] = tb;
          end
        end
      end
      set_done = 1'b1;
    end
  endfunction

  function automatic answer_t book_lookup(input logic [15:0] key);
    answer_t ans;
    int      bal;
    int      lim;
    ans = '0;
    lim = limit_q;
    for (int i = 0; i < n_stored; i++) begin
      if (key_mem[i] == key) begin
        bal = $signed(bal_mem[i]);
        ans.hit = 1'b1;
        ans.found_balance = bal_mem[i];
        ans.over_limit = bal > lim;
        break;
      end
      if (key_mem[i] > key) break;
    end
    return ans;
  endfunction

  task automatic send_req(input logic req, input logic [15:0] key, input logic [23:0] bal,
                          input logic last);
    answer_t ans;
    while (!steady && $urandom_range(99) < 16) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {bal, key};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_items++;
    if (req == ReqLoad) begin
      book_load(key, bal, last);
    end else begin
      ans = book_lookup(key);
      n_lookups++;
      if (ans.hit) n_hits++;
      pending_answers.push_back(ans);
    end
  endtask

  task automatic drain_answers();
    s_axis_tvalid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // The limit is only changed with the core idle: all answers in, sort finished.
  task automatic write_limit(input logic [22:0] lim);
    drain_answers();
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_q = lim;
    n_limits++;
  endtask

  function automatic logic [23:0] pick_balance();
    int unsigned sel;
    int          b;
    sel = $urandom_range(99);
    if (sel < 30) begin
      b = int'(limit_q) + int'($urandom_range(2)) - 1;
      if (b > 8388607) b = 8388607;
    end else if (sel < 40) begin
      case ($urandom_range(3))
        0:       b = -8388608;
        1:       b = 8388607;
        2:       b = 0;
        default: b = -1;
      endcase
    end else if (sel < 55) begin
      b = int'($urandom_range(40000)) - 20000;
    end else begin
      b = $signed($urandom() & 32'hFFFFFF) << 8 >>> 8;
    end
    return b[23:0];
  endfunction

  function automatic logic [15:0] pick_query(input logic [15:0] keys[$]);
    int unsigned sel;
    logic [15:0] k;
    sel = $urandom_range(99);
    if (keys.size() == 0 || sel >= 80) return 16'($urandom());
    k = keys[$urandom_range(keys.size() - 1)];
    if (sel < 60) return k;
    return $urandom_range(1) ? k + 16'd1 : k - 16'd1;
  endfunction

  task automatic send_lookup(input logic [15:0] key);
    send_req(ReqLookup, key, 24'($urandom()), 1'($urandom()));
  endtask

  // One set of loads, an occasional lookup while it is still open, then lookups.
  task automatic run_set(input int unsigned n_loads, input bit narrow, input bit close,
                         input int unsigned n_looks);
    logic [15:0] keys[$];
    logic [15:0] base;
    logic [15:0] k;
    int unsigned early;
    base  = 16'($urandom());
    early = $urandom_range(n_loads - 1);
    for (int i = 0; i < n_loads; i++) begin
      k = narrow ? base + 16'($urandom_range(31)) : 16'($urandom());
      keys.push_back(k);
      send_req(ReqLoad, k, pick_balance(), close && (i == n_loads - 1));
      if (i == early && $urandom_range(3) == 0) send_lookup(pick_query(keys));
    end
    for (int i = 0; i < n_looks; i++) send_lookup(pick_query(keys));
  endtask

  task automatic test_empty_store();
    send_req(ReqLookup, 16'h0000, 24'hFFFFFF, 1'b1);
    send_req(ReqLookup, 16'hFFFF, 24'h000000, 1'b0);
  endtask

  task automatic test_directed_set();
    send_req(ReqLoad, 16'hFFFF, 24'h7FFFFF, 1'b0);
    send_req(ReqLoad, 16'h0000, 24'h800000, 1'b0);
    send_req(ReqLoad, 16'd300, 24'd10000, 1'b0);
    // Open set in arrival order: the first key already passes 300, so the walk stops.
    send_lookup(16'd300);
    send_lookup(16'hFFFF);
    send_req(ReqLoad, 16'd300, 24'd10001, 1'b0);
    send_req(ReqLoad, 16'd42, 24'd10001, 1'b1);
    send_lookup(16'h0000);
    send_lookup(16'd42);
    send_lookup(16'd300);
    send_lookup(16'hFFFF);
    send_lookup(16'd41);
    send_lookup(16'd43);
    send_lookup(16'd301);
    send_lookup(16'hFFFE);
    // A load after the set is closed starts a new one.
    send_req(ReqLoad, 16'd7, 24'd5, 1'b0);
    send_lookup(16'h0000);
    send_lookup(16'd7);
    send_req(ReqLoad, 16'd7, 24'd10000, 1'b1);
    send_lookup(16'd7);
  endtask

  task automatic test_capacity();
    run_set(20, 1'b1, 1'b1, 10);
    run_set(ENTRIES, 1'b1, 1'b1, 8);
    run_set(ENTRIES + 1, 1'b0, 1'b1, 6);
  endtask

  task automatic test_limit_settings();
    logic [22:0] limits[5];
    limits = '{23'd0, 23'h7FFFFF, 23'($urandom()), 23'($urandom_range(20000)), LimitReset};
    foreach (limits[i]) begin
      write_limit(limits[i]);
      for (int s = 0; s < 3; s++) run_set($urandom_range(6, 1), 1'b1, 1'b1, 6);
    end
  endtask

  task automatic test_backpressure();
    run_set(8, 1'b1, 1'b1, 0);
    stall_req = 1'b1;
    for (int i = 0; i < 12; i++) send_lookup(16'($urandom_range(65535)));
    drain_answers();
  endtask

  task automatic test_random();
    int unsigned sel;
    int unsigned len;
    while (n_items < N_ITEMS) begin
      steady = (n_items >= 700 && n_items < 900);
      sel = $urandom_range(99);
      if (sel < 80) begin
        len = $urandom_range(99);
        len = (len < 70) ? $urandom_range(6, 1) :
              (len < 95) ? $urandom_range(16, 7) : $urandom_range(20, 17);
        run_set(len, 1'($urandom_range(1)), $urandom_range(9) != 0, $urandom_range(8, 2));
      end else if (sel < 90) begin
        send_lookup(16'($urandom()));
      end else begin
        send_req(ReqLoad, 16'($urandom()), pick_balance(), 1'($urandom()));
      end
    end
    steady = 1'b0;
  endtask

  // Receiver side: random back pressure, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_req && !stall_done) begin
      m_axis_tready_i <= 1'b0;
      if (stall_cnt == STALL_LEN - 1) begin
        stall_done = 1'b1;
      end else begin
        stall_cnt++;
      end
    end else begin
      m_axis_tready_i <= steady || ($urandom_range(99) >= 16);
    end
  end

  function automatic void flag_mismatch(input string field, input int want, input int got);
    n_errors++;
    if (n_errors <= 60)
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  always @(posedge clk_i) begin : check_answers
    answer_t want;
    answer_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[25:0];
      if (pending_answers.size() == 0) begin
        flag_mismatch("unrequested answer", 0, m_axis_tdata_o);
      end else begin
        want = pending_answers.pop_front();
        if (got.hit !== want.hit) flag_mismatch("hit", want.hit, got.hit);
        if (got.found_balance !== want.found_balance)
          flag_mismatch("found_balance", want.found_balance, got.found_balance);
        if (got.over_limit !== want.over_limit)
          flag_mismatch("over_limit", want.over_limit, got.over_limit);
        if (m_axis_tdata_o[31:26] !== 6'd0)
          flag_mismatch("padding", 0, m_axis_tdata_o[31:26]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("Timeout after %0d cycles, %0d answers outstanding", cycles,
               pending_answers.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_directed_set();
    test_capacity();
    test_limit_settings();
    test_backpressure();
    test_random();
    drain_answers();
    repeat (SETTLE) @(posedge clk_i);
    if (pending_answers.size() != 0) flag_mismatch("answers left", 0, pending_answers.size());
    $display("Covered %0d requests, %0d lookups (%0d hits) under %0d credit limits,",
             n_items, n_lookups, n_hits, n_limits + 1);
    $display("with full and overfilled stores, open-set lookups and a long output stall.");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/skbl_pkg.sv
rtl/skbl_dpath.sv
rtl/skbl_ctrl.sv
rtl/sorted_key_balance_lookup_core.sv
verif/tb_sorted_key_balance_lookup_core.sv
